// File: src/msfa_pkg.sv
// Package for the multitouch slot frame assembler: event codes, payload
// structs, queue command format and back-end state type. No dependencies.
`default_nettype none
package msfa_pkg;

   localparam logic [4:0] EV_SYNC     = 5'd0;
   localparam logic [4:0] EV_AXIS     = 5'd3;
   localparam logic [9:0] CODE_REPORT = 10'd0;
   localparam logic [9:0] CODE_SLOT   = 10'd47;
   localparam logic [9:0] CODE_X      = 10'd53;
   localparam logic [9:0] CODE_Y      = 10'd54;
   localparam logic [9:0] CODE_ID     = 10'd57;

   localparam logic signed [31:0] NO_ID   = -32'sd2;
   localparam logic signed [31:0] LIFT_ID = -32'sd1;

   localparam logic [1:0] KIND_CONTACT = 2'd0;
   localparam logic [1:0] KIND_LIFT    = 2'd1;
   localparam logic [1:0] KIND_MOVE    = 2'd2;

   localparam int         SLOTS_DEFAULT = 16;
   localparam int         MAX_OUT       = 16;
   localparam logic [4:0] SIU_RESET     = 5'd16;
   localparam int         QUEUE_DEPTH   = 4;

   typedef struct packed {
      logic [4:0]         mode;
      logic [9:0]         event_code;
      logic signed [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         slot_number;
      logic               touch_valid;
      logic [1:0]         touch_kind;
      logic signed [31:0] tracking_id;
      logic [15:0]        touch_x;
      logic [15:0]        touch_y;
      logic               frame_last;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_SLOT,
      CMD_X,
      CMD_Y,
      CMD_ID,
      CMD_SYNC
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         report;
      logic [31:0]  data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

endpackage
`default_nettype wire

// File: src/msfa_front.sv
// Front end: accepts requests, drops ignored events, saturates coordinates
// and range-checks slot selects. Depends on msfa_pkg.
`default_nettype none
module msfa_front #(
   parameter int SLOTS = msfa_pkg::SLOTS_DEFAULT
) (
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire msfa_pkg::req_type          req_data,
   input  wire msfa_pkg::queue_status_type q_status,
   output logic                            q_push,
   output msfa_pkg::cmd_type               q_cmd
);

   logic        accept;
   logic        is_axis;
   logic        is_sync;
   logic        slot_ok;
   logic [15:0] sat_val;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign is_axis   = (req_data.mode == msfa_pkg::EV_AXIS);
   assign is_sync   = (req_data.mode == msfa_pkg::EV_SYNC);
   assign slot_ok   = !req_data.event_value[31] &&
                      ($unsigned(req_data.event_value) < 32'(SLOTS));

   always_comb begin
      if (req_data.event_value[31]) begin
         sat_val = 16'd0;
      end else if (|req_data.event_value[30:16]) begin
         sat_val = 16'hFFFF;
      end else begin
         sat_val = req_data.event_value[15:0];
      end
   end

   always_comb begin
      q_push        = 1'b0;
      q_cmd.kind    = msfa_pkg::CMD_SYNC;
      q_cmd.report  = (req_data.event_code == msfa_pkg::CODE_REPORT);
      q_cmd.data    = req_data.event_value;
      if (is_sync) begin
         q_push = accept;
      end else if (is_axis) begin
         case (req_data.event_code)
            msfa_pkg::CODE_SLOT: begin
               q_cmd.kind = msfa_pkg::CMD_SLOT;
               q_push     = accept && slot_ok;
            end
            msfa_pkg::CODE_X: begin
               q_cmd.kind = msfa_pkg::CMD_X;
               q_cmd.data = {16'd0, sat_val};
               q_push     = accept;
            end
            msfa_pkg::CODE_Y: begin
               q_cmd.kind = msfa_pkg::CMD_Y;
               q_cmd.data = {16'd0, sat_val};
               q_push     = accept;
            end
            msfa_pkg::CODE_ID: begin
               q_cmd.kind = msfa_pkg::CMD_ID;
               q_push     = accept;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: src/msfa_queue.sv
// Short command queue between front and back ends.
// Depends on msfa_pkg.
`default_nettype none
module msfa_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire msfa_pkg::cmd_type          push_cmd,
   input  wire logic                       pop,
   output msfa_pkg::cmd_type               pop_cmd,
   output msfa_pkg::queue_status_type      status
);

   localparam int PTR_W = $clog2(msfa_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   msfa_pkg::cmd_type  entry_ff [msfa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == CNT_W'(msfa_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: src/msfa_back.sv
// Back end: slot state, coordinate and id memories, frame emission into
// the result register, and the slots_in_use register. Depends on msfa_pkg.
`default_nettype none
module msfa_back #(
   parameter int SLOTS = msfa_pkg::SLOTS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [4:0]                 csr_data,
   input  wire msfa_pkg::queue_status_type q_status,
   input  wire msfa_pkg::cmd_type          q_cmd,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output msfa_pkg::rsp_type               rsp_data
);

   localparam int         SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int         CAP    = (SLOTS < msfa_pkg::MAX_OUT) ? SLOTS : msfa_pkg::MAX_OUT;
   localparam logic [4:0] CAP5   = 5'(CAP);

   msfa_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [3:0]          k_ff, k_in;
   logic [4:0]          n_ff, n_in;
   logic                report_ff, report_in;
   logic [SLOTS-1:0]    mark_ff, mark_in;
   logic [SLOTS-1:0]    id_set_ff, id_set_in;
   logic [SLOTS-1:0]    x_wr_ff, x_wr_in;
   logic [SLOTS-1:0]    y_wr_ff, y_wr_in;
   logic [4:0]          siu_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   msfa_pkg::rsp_type   rsp_ff, rsp_in;

   logic [15:0]        x_mem  [SLOTS];
   logic [15:0]        y_mem  [SLOTS];
   logic [31:0]        id_mem [SLOTS];
   logic [15:0]        rd_x_ff;
   logic [15:0]        rd_y_ff;
   logic signed [31:0] rd_id_ff;

   logic                   wr_x, wr_y, wr_id;
   logic [SLOT_W+3:0]      k_ext;
   logic [SLOT_W-1:0]      rd_addr;
   logic [4:0]             n_sel;
   logic                   out_free;
   logic                   last;
   logic                   rsp_load;
   logic signed [31:0]     id_val;
   logic [1:0]             kind;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign k_ext    = {{SLOT_W{1'b0}}, k_ff};
   assign rd_addr  = k_ext[SLOT_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last     = (({1'b0, k_ff} + 5'd1) == n_ff);
   assign rsp_load = (state_ff == msfa_pkg::ST_SEND) && out_free;
   assign id_val   = id_set_ff[rd_addr] ? rd_id_ff : msfa_pkg::NO_ID;

   always_comb begin
      if (siu_ff == 5'd0) begin
         n_sel = 5'd1;
      end else if (siu_ff > CAP5) begin
         n_sel = CAP5;
      end else begin
         n_sel = siu_ff;
      end
   end

   always_comb begin
      if (!id_val[31]) begin
         kind = msfa_pkg::KIND_CONTACT;
      end else if (id_val == msfa_pkg::LIFT_ID) begin
         kind = msfa_pkg::KIND_LIFT;
      end else begin
         kind = msfa_pkg::KIND_MOVE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      report_in    = report_ff;
      mark_in      = mark_ff;
      id_set_in    = id_set_ff;
      x_wr_in      = x_wr_ff;
      y_wr_in      = y_wr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_x         = 1'b0;
      wr_y         = 1'b0;
      wr_id        = 1'b0;
      case (state_ff)
         msfa_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  msfa_pkg::CMD_SLOT: begin
                     cur_in = q_cmd.data[SLOT_W-1:0];
                  end
                  msfa_pkg::CMD_X: begin
                     wr_x            = 1'b1;
                     x_wr_in[cur_ff] = 1'b1;
                     mark_in[cur_ff] = 1'b1;
                  end
                  msfa_pkg::CMD_Y: begin
                     wr_y            = 1'b1;
                     y_wr_in[cur_ff] = 1'b1;
                     mark_in[cur_ff] = 1'b1;
                  end
                  msfa_pkg::CMD_ID: begin
                     wr_id             = 1'b1;
                     id_set_in[cur_ff] = 1'b1;
                     mark_in[cur_ff]   = 1'b1;
                  end
                  msfa_pkg::CMD_SYNC: begin
                     report_in = q_cmd.report;
                     n_in      = n_sel;
                     k_in      = 4'd0;
                     state_in  = msfa_pkg::ST_READ;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         msfa_pkg::ST_READ: begin
            state_in = msfa_pkg::ST_SEND;
         end
         msfa_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.slot_number = k_ff;
               rsp_in.touch_valid = mark_ff[rd_addr];
               rsp_in.touch_kind  = kind;
               rsp_in.tracking_id = id_val;
               rsp_in.touch_x     = (report_ff && x_wr_ff[rd_addr]) ? rd_x_ff : 16'd0;
               rsp_in.touch_y     = (report_ff && y_wr_ff[rd_addr]) ? rd_y_ff : 16'd0;
               rsp_in.frame_last  = last;
               if (last) begin
                  mark_in   = '0;
                  id_set_in = '0;
                  state_in  = msfa_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = msfa_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = msfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msfa_pkg::ST_IDLE;
         cur_ff       <= '0;
         k_ff         <= '0;
         n_ff         <= 5'd1;
         report_ff    <= 1'b0;
         mark_ff      <= '0;
         id_set_ff    <= '0;
         x_wr_ff      <= '0;
         y_wr_ff      <= '0;
         siu_ff       <= msfa_pkg::SIU_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         report_ff    <= report_in;
         mark_ff      <= mark_in;
         id_set_ff    <= id_set_in;
         x_wr_ff      <= x_wr_in;
         y_wr_ff      <= y_wr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            siu_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_x) begin
         x_mem[cur_ff] <= q_cmd.data[15:0];
      end
      rd_x_ff <= x_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_y) begin
         y_mem[cur_ff] <= q_cmd.data[15:0];
      end
      rd_y_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_id) begin
         id_mem[cur_ff] <= q_cmd.data;
      end
      rd_id_ff <= id_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_k_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff != msfa_pkg::ST_IDLE) |-> ({1'b0, k_ff} < n_ff))
      else $error("slot counter past frame length");

   a_n_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != msfa_pkg::ST_IDLE) |-> (n_ff >= 5'd1 && n_ff <= CAP5))
      else $error("frame length out of range");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last) |=> (mark_ff == '0 && id_set_ff == '0 && rsp_data.frame_last))
      else $error("frame marks not cleared after last result");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msfa_pkg::ST_READ) |=> (state_ff == msfa_pkg::ST_SEND && !q_pop))
      else $error("read stage did not advance to send");
`endif

endmodule
`default_nettype wire

// File: src/multitouch_slot_frame_assembler_core.sv
// Top level of the multitouch slot frame assembler: front end, command
// queue and back end. Depends on msfa_pkg, msfa_front, msfa_queue, msfa_back.
//
// Usage:
//   req_*  : input events (mode, event_code, event_value), valid/stall.
//            One request per cycle is taken while the command queue has room;
//            req_stall is high when the four-entry queue is full.
//   rsp_*  : slot results, valid/stall, from one output register.
//   csr_*  : write of slots_in_use (valid/ready, always ready).
// Axis events are applied by the back end while it is idle. A sync event emits
// min(max(slots_in_use,1), SLOTS, 16) results; each result takes a memory
// read state (ST_READ) and then an output register load (ST_SEND), and the
// back end takes no queue entries until the frame's last result is loaded.
// While rsp_stall is high and a result is valid, the result register holds and the back end waits;
// requests keep entering the queue until it fills.
// Reset (synchronous, active high) clears the queue, slot state, valid marks
// and sets slots_in_use to 16; no clearing pass is needed.
`default_nettype none
module multitouch_slot_frame_assembler_core #(
   parameter int SLOTS = msfa_pkg::SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire msfa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output msfa_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [4:0]        csr_data
);

   msfa_pkg::queue_status_type q_status;
   msfa_pkg::cmd_type          push_cmd;
   msfa_pkg::cmd_type          pop_cmd;
   logic                       q_push;
   logic                       q_pop;

   msfa_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   msfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   msfa_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for multitouch_slot_frame_assembler_core: predicts slot
// frames from the accepted event stream and checks every slot result in order.
// Depends on msfa_pkg and the assembler core RTL.
module tb_top;

   localparam int NUM_SLOTS        = msfa_pkg::SLOTS_DEFAULT;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int RANDOM_EVENTS    = 320;
   localparam int TIMEOUT_NS       = 40_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   msfa_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   msfa_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [4:0]        csr_data = '0;

   // touch state tracker
   logic [4:0]         slots_cfg;
   logic [3:0]         cur_slot;
   logic [15:0]        x_mem [NUM_SLOTS];
   logic [15:0]        y_mem [NUM_SLOTS];
   logic               seen_mem [NUM_SLOTS];
   logic signed [31:0] id_mem [NUM_SLOTS];

   msfa_pkg::rsp_type expected_slots [$];
   int      error_count = 0;
   int      events_counted = 0;
   bit      gaps_enabled = 1'b1;
   bit      long_hold_req = 1'b0;

   multitouch_slot_frame_assembler_core #(
      .SLOTS(NUM_SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   function automatic int frame_len();
      int n;
      int cap;
      n = slots_cfg;
      cap = (NUM_SLOTS < msfa_pkg::MAX_OUT) ? NUM_SLOTS : msfa_pkg::MAX_OUT;
      if (n < 1) n = 1;
      if (n > cap) n = cap;
      return n;
   endfunction

   function automatic void clear_touch_frame();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         seen_mem[i] = 1'b0;
         id_mem[i] = msfa_pkg::NO_ID;
      end
   endfunction

   function automatic void reset_touch_state();
      slots_cfg = msfa_pkg::SIU_RESET;
      cur_slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         x_mem[i] = '0;
         y_mem[i] = '0;
      end
      clear_touch_frame();
   endfunction

   function automatic logic [15:0] clamp_coord(logic signed [31:0] v);
      if (v < 0) return 16'h0000;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic void predict_touch_event(msfa_pkg::req_type ev);
      logic signed [31:0] val;
      msfa_pkg::rsp_type r;
      int n;
      bit report;
      val = ev.event_value;
      if (ev.mode == msfa_pkg::EV_AXIS) begin
         if (ev.event_code == msfa_pkg::CODE_SLOT) begin
            if (val >= 0 && val < NUM_SLOTS) cur_slot = val[3:0];
         end else if (ev.event_code == msfa_pkg::CODE_X) begin
            x_mem[cur_slot] = clamp_coord(val);
            seen_mem[cur_slot] = 1'b1;
         end else if (ev.event_code == msfa_pkg::CODE_Y) begin
            y_mem[cur_slot] = clamp_coord(val);
            seen_mem[cur_slot] = 1'b1;
         end else if (ev.event_code == msfa_pkg::CODE_ID) begin
            id_mem[cur_slot] = val;
            seen_mem[cur_slot] = 1'b1;
         end
      end else if (ev.mode == msfa_pkg::EV_SYNC) begin
         n = frame_len();
         report = (ev.event_code == msfa_pkg::CODE_REPORT);
         for (int k = 0; k < n; k++) begin
            r.slot_number = k[3:0];
            r.touch_valid = seen_mem[k];
            if (id_mem[k] >= 0) r.touch_kind = msfa_pkg::KIND_CONTACT;
            else if (id_mem[k] == msfa_pkg::LIFT_ID) r.touch_kind = msfa_pkg::KIND_LIFT;
            else r.touch_kind = msfa_pkg::KIND_MOVE;
            r.tracking_id = id_mem[k];
            r.touch_x = report ? x_mem[k] : 16'h0000;
            r.touch_y = report ? y_mem[k] : 16'h0000;
            r.frame_last = (k + 1 == n);
            expected_slots.push_back(r);
         end
         clear_touch_frame();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_touch_state();
      end else begin
         if (csr_valid && csr_ready) slots_cfg = csr_data;
         if (req_valid && !req_stall) predict_touch_event(req_data);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      msfa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_slots.size() == 0) begin
            $display("%0t ns: unexpected slot result, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_slots.pop_front();
            check_field("slot_number", want.slot_number, rsp_data.slot_number);
            check_field("touch_valid", want.touch_valid, rsp_data.touch_valid);
            check_field("touch_kind", want.touch_kind, rsp_data.touch_kind);
            check_field("tracking_id", want.tracking_id, rsp_data.tracking_id);
            check_field("touch_x", want.touch_x, rsp_data.touch_x);
            check_field("touch_y", want.touch_y, rsp_data.touch_y);
            check_field("frame_last", want.frame_last, rsp_data.frame_last);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (!gaps_enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result-side stall generator; long hold counted here
   initial begin : rsp_stall_gen
      int  run_left;
      bit  level;
      run_left = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_req = 1'b0;
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               if (!gaps_enabled) begin
                  level = 1'b0;
                  run_left = 1;
               end else begin
                  level = ($urandom_range(0, 2) == 0);
                  run_left = level ? 1 + pick_gap() : $urandom_range(1, 12);
               end
            end
            rsp_stall <= level;
            run_left--;
         end
      end
   end

   function automatic msfa_pkg::req_type mk_event(logic [4:0] mode, logic [9:0] code,
                                                  logic [31:0] value);
      msfa_pkg::req_type ev;
      ev.mode = mode;
      ev.event_code = code;
      ev.event_value = value;
      return ev;
   endfunction

   task automatic send_event(input msfa_pkg::req_type ev);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= ev;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (ev.mode == msfa_pkg::EV_SYNC ||
          (ev.mode == msfa_pkg::EV_AXIS &&
           (ev.event_code == msfa_pkg::CODE_SLOT || ev.event_code == msfa_pkg::CODE_X ||
            ev.event_code == msfa_pkg::CODE_Y || ev.event_code == msfa_pkg::CODE_ID)))
         events_counted++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_slots_in_use(input logic [4:0] value);
      drain_results();
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 65535);
      if (r == 6) return {1'b1, 31'($urandom)};
      if (r == 7) return $urandom_range(65536, 32'h7FFFFFFF);
      if (r == 8) return 32'd0;
      return 32'd65535;
   endfunction

   function automatic logic [31:0] random_track_id();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 1000);
      if (r < 7) return msfa_pkg::LIFT_ID;
      if (r == 7) return msfa_pkg::NO_ID;
      return $urandom;
   endfunction

   function automatic logic [31:0] random_slot_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return $urandom_range(0, frame_len() - 1);
      if (r == 8) return $urandom_range(0, NUM_SLOTS - 1);
      return $urandom;
   endfunction

   function automatic logic [4:0] random_setting();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 4);
      if (r == 6) return 5'd0;
      if (r == 7) return 5'd16;
      if (r == 8) return 5'd31;
      return $urandom_range(0, 31);
   endfunction

   task automatic send_frame();
      int touches;
      touches = $urandom_range(0, 4);
      for (int t = 0; t < touches; t++) begin
         if ($urandom_range(0, 9) != 0)
            send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, random_slot_value()));
         if ($urandom_range(0, 2) != 0)
            send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_ID, random_track_id()));
         if ($urandom_range(0, 3) != 0)
            send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, random_coord()));
         if ($urandom_range(0, 3) != 0)
            send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_Y, random_coord()));
      end
      send_event(mk_event(msfa_pkg::EV_SYNC,
                          ($urandom_range(0, 9) == 0) ? 10'($urandom) : msfa_pkg::CODE_REPORT,
                          $urandom));
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1) == 0)
         send_event(mk_event(5'($urandom), 10'($urandom), $urandom));
      else
         send_event(mk_event(msfa_pkg::EV_AXIS, 10'($urandom), $urandom));
   endtask

   task automatic test_reset_state();
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
   endtask

   task automatic test_event_decode();
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd0));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_ID, 32'd5));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, 32'd100));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_Y, 32'd200));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd15));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_ID, msfa_pkg::LIFT_ID));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, -32'sd5));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_Y, 32'd70000));
      // out-of-range slot selects keep slot 15
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd16));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, -32'sd1));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'h8000_0000));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, 32'd65535));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd7));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_ID, 32'h8000_0000));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, 32'h7FFF_FFFF));
      // ignored events
      send_event(mk_event(5'd1, msfa_pkg::CODE_X, 32'd9));
      send_event(mk_event(5'd31, 10'd1023, 32'hFFFF_FFFF));
      send_event(mk_event(msfa_pkg::EV_AXIS, 10'd0, 32'd3));
      send_event(mk_event(msfa_pkg::EV_AXIS, 10'd1023, 32'd3));
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd3));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_ID, msfa_pkg::NO_ID));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_Y, 32'd1234));
      // non-report syncs zero the coordinates
      send_event(mk_event(msfa_pkg::EV_SYNC, 10'd1023, 32'd0));
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_SLOT, 32'd1));
   endtask

   task automatic test_slots_config();
      write_slots_in_use(5'd1);
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      write_slots_in_use(5'd0);
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      write_slots_in_use(5'd31);
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      write_slots_in_use(5'd17);
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      write_slots_in_use(5'd2);
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_SLOT, 32'd5));
      send_event(mk_event(msfa_pkg::EV_AXIS, msfa_pkg::CODE_X, 32'd77));
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
   endtask

   task automatic test_backpressure();
      write_slots_in_use(5'd8);
      long_hold_req = 1'b1;
      repeat (2) @(negedge clock);
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      for (int i = 0; i < 12; i++)
         send_event(mk_event(msfa_pkg::EV_AXIS,
                             (i % 2) ? msfa_pkg::CODE_X : msfa_pkg::CODE_Y,
                             random_coord()));
      send_event(mk_event(msfa_pkg::EV_SYNC, msfa_pkg::CODE_REPORT, 32'd0));
      while (long_hold_req) @(negedge clock);
   endtask

   task automatic test_random_frames();
      int frame_no;
      int start_count;
      frame_no = 0;
      start_count = events_counted;
      while (events_counted - start_count < RANDOM_EVENTS) begin
         if (frame_no % 8 == 7) write_slots_in_use(random_setting());
         gaps_enabled = (frame_no % 25) < 21;
         if ($urandom_range(0, 5) == 0) send_noise();
         send_frame();
         frame_no++;
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_event_decode();
      test_slots_config();
      test_backpressure();
      test_random_frames();
      drain_results();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
